[sv/nnsa_pkg.sv]
// nnsa_pkg: types and constants of the nearest neighbour scale address core
// no dependencies
package nnsa_pkg;

   localparam int DIM_W     = 13;
   localparam int COORD_W   = 12;
   localparam int QUO_W     = 13;
   localparam int PROD_W    = COORD_W + DIM_W;
   localparam int REM_W     = PROD_W + 1;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIP       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT      = 3'd5;

   localparam logic [1:0] SPLIT_LEFT  = 2'd1;
   localparam logic [1:0] SPLIT_RIGHT = 2'd2;

   typedef struct packed {
      logic [DIM_W-1:0] src_width;
      logic [DIM_W-1:0] src_height;
      logic [DIM_W-1:0] dst_width;
      logic [DIM_W-1:0] dst_height;
      logic             flip_vertical;
      logic [1:0]       split_mode;
   } cfg_type;

   typedef struct packed {
      logic               skip;
      logic               fill;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] y_ofs;
      logic [COORD_W-1:0] x_ofs;
      logic [DIM_W-1:0]   src_width;
      logic [DIM_W-1:0]   src_height;
      logic [DIM_W-1:0]   dst_height;
      logic [DIM_W-1:0]   active;
   } item_type;

endpackage

[sv/nnsa_front.sv]
// nnsa_front: accepts coordinates, classifies skip and fill, computes offsets
// depends on nnsa_pkg
module nnsa_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [nnsa_pkg::COORD_W-1:0]   req_dest_x,
   input  logic [nnsa_pkg::COORD_W-1:0]   req_dest_y,
   input  nnsa_pkg::cfg_type              cfg,
   output logic                           out_valid,
   output nnsa_pkg::item_type             out_item,
   input  logic                           out_ready
);
   logic                 valid_ff, valid_in;
   nnsa_pkg::item_type   item_ff, item_in;
   logic [nnsa_pkg::DIM_W-1:0] x13, y13, half, lo, hi;
   logic zero, oob, fill, take;

   assign busy = valid_ff && !out_ready;
   assign take = start && !busy;

   always_comb begin
      x13  = {1'b0, req_dest_x};
      y13  = {1'b0, req_dest_y};
      half = cfg.dst_width >> 1;
      lo   = '0;
      hi   = cfg.dst_width;
      if (cfg.split_mode == nnsa_pkg::SPLIT_LEFT) begin
         hi = half;
      end else if (cfg.split_mode == nnsa_pkg::SPLIT_RIGHT) begin
         lo = half;
      end
      zero = (cfg.src_width == '0) || (cfg.src_height == '0) ||
             (cfg.dst_width == '0) || (cfg.dst_height == '0);
      oob  = (x13 >= cfg.dst_width) || (y13 >= cfg.dst_height);
      fill = (x13 < lo) || (x13 >= hi);
      item_in.skip       = zero || oob;
      item_in.fill       = fill && !(zero || oob);
      item_in.row        = cfg.flip_vertical ?
                           nnsa_pkg::COORD_W'(cfg.dst_height - 13'd1 - y13) : req_dest_y;
      item_in.y_ofs      = req_dest_y;
      item_in.x_ofs      = nnsa_pkg::COORD_W'(x13 - lo);
      item_in.src_width  = cfg.src_width;
      item_in.src_height = cfg.src_height;
      item_in.dst_height = cfg.dst_height;
      item_in.active     = hi - lo;
      valid_in = take ? 1'b1 : (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

[sv/nnsa_queue.sv]
// nnsa_queue: two entry queue between front and back
// depends on nnsa_pkg
module nnsa_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  nnsa_pkg::item_type  in_item,
   output logic                in_ready,
   output logic                out_valid,
   output nnsa_pkg::item_type  out_item,
   input  logic                out_ready
);
   nnsa_pkg::item_type mem_ff [2];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule

[sv/nnsa_back.sv]
// nnsa_back: multiply stage and pipelined restoring dividers for both axes
// depends on nnsa_pkg
module nnsa_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  nnsa_pkg::item_type            in_item,
   output logic                          rsp_valid,
   output logic [nnsa_pkg::COORD_W-1:0]  rsp_source_x,
   output logic [nnsa_pkg::COORD_W-1:0]  rsp_source_y,
   output logic [nnsa_pkg::COORD_W-1:0]  rsp_dest_row,
   output logic                          rsp_fill_black,
   output logic                          rsp_skip
);
   localparam int N = nnsa_pkg::QUO_W;
   localparam int RW = nnsa_pkg::REM_W;

   typedef struct packed {
      logic                         skip;
      logic                         fill;
      logic [nnsa_pkg::COORD_W-1:0] row;
      logic [RW-1:0]                rem_x;
      logic [RW-1:0]                rem_y;
      logic [N-1:0]                 q_x;
      logic [N-1:0]                 q_y;
      logic [nnsa_pkg::DIM_W-1:0]   div_x;
      logic [nnsa_pkg::DIM_W-1:0]   div_y;
   } stage_type;

   logic      valid_ff [N+1];
   stage_type stage_ff [N+1];
   stage_type first_in;

   always_comb begin
      first_in.skip  = in_item.skip;
      first_in.fill  = in_item.fill;
      first_in.row   = in_item.row;
      first_in.rem_x = RW'(in_item.x_ofs) * RW'(in_item.src_width);
      first_in.rem_y = RW'(in_item.y_ofs) * RW'(in_item.src_height);
      first_in.q_x   = '0;
      first_in.q_y   = '0;
      first_in.div_x = in_item.active;
      first_in.div_y = in_item.dst_height;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      stage_ff[0] <= first_in;
   end

   for (genvar s = 0; s < N; s++) begin : g_div
      localparam int K = N - 1 - s;
      stage_type stage_in;
      logic [RW-1:0] dx, dy;
      always_comb begin
         stage_in = stage_ff[s];
         dx = RW'(stage_ff[s].div_x) << K;
         dy = RW'(stage_ff[s].div_y) << K;
         if (stage_ff[s].rem_x >= dx) begin
            stage_in.rem_x  = stage_ff[s].rem_x - dx;
            stage_in.q_x[K] = 1'b1;
         end
         if (stage_ff[s].rem_y >= dy) begin
            stage_in.rem_y  = stage_ff[s].rem_y - dy;
            stage_in.q_y[K] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_ff[s];
         end
         stage_ff[s+1] <= stage_in;
      end
   end

   assign rsp_valid      = valid_ff[N];
   assign rsp_skip       = stage_ff[N].skip;
   assign rsp_fill_black = stage_ff[N].fill;
   assign rsp_source_x   = (stage_ff[N].skip || stage_ff[N].fill) ? '0 :
                           stage_ff[N].q_x[nnsa_pkg::COORD_W-1:0];
   assign rsp_source_y   = stage_ff[N].skip ? '0 : stage_ff[N].q_y[nnsa_pkg::COORD_W-1:0];
   assign rsp_dest_row   = stage_ff[N].skip ? '0 : stage_ff[N].row;
endmodule

[sv/nearest_neighbour_scale_address_core.sv]
// nearest_neighbour_scale_address_core: top level, csr registers and pipeline
// depends on nnsa_pkg, nnsa_front, nnsa_queue, nnsa_back
//
// usage:
//   csr channel: csr_valid/csr_ready with csr_index and csr_data; csr_ready is
//   always high; write sizes, flip and split mode while the core is idle
//   request: a transfer happens when start is high and busy is low; it carries
//   req_dest_x and req_dest_y
//   response: rsp_valid strobes for one cycle with source_x, source_y,
//   dest_row, fill_black and skip; the receiver cannot stall
//   path: from request transfer to response strobe through the front register,
//   queue, multiply stage and 13 divider stages
//   throughput: one coordinate per cycle; the divider stages retire one
//   quotient bit each, so the pipeline never holds the queue back
//   reset: synchronous, clears all csr registers to zero and empties the
//   pipeline; sizes above MAX_DIM are clamped on write
module nearest_neighbour_scale_address_core #(
   parameter int MAX_DIM = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [nnsa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nnsa_pkg::DIM_W-1:0]     csr_data,
   input  logic                           start,
   output logic                           busy,
   input  logic [nnsa_pkg::COORD_W-1:0]   req_dest_x,
   input  logic [nnsa_pkg::COORD_W-1:0]   req_dest_y,
   output logic                           rsp_valid,
   output logic [nnsa_pkg::COORD_W-1:0]   rsp_source_x,
   output logic [nnsa_pkg::COORD_W-1:0]   rsp_source_y,
   output logic [nnsa_pkg::COORD_W-1:0]   rsp_dest_row,
   output logic                           rsp_fill_black,
   output logic                           rsp_skip
);
   localparam logic [nnsa_pkg::DIM_W+1:0] MAX_W = (nnsa_pkg::DIM_W+2)'(MAX_DIM);

   nnsa_pkg::cfg_type  cfg_ff, cfg_in;
   nnsa_pkg::item_type front_item, queue_item;
   logic front_valid, queue_ready, queue_valid;
   logic [nnsa_pkg::DIM_W-1:0] dim;

   assign csr_ready = 1'b1;

   always_comb begin
      dim = ({2'b00, csr_data} > MAX_W) ? nnsa_pkg::DIM_W'(MAX_W) : csr_data;
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            nnsa_pkg::CSR_SRC_WIDTH:  cfg_in.src_width     = dim;
            nnsa_pkg::CSR_SRC_HEIGHT: cfg_in.src_height    = dim;
            nnsa_pkg::CSR_DST_WIDTH:  cfg_in.dst_width     = dim;
            nnsa_pkg::CSR_DST_HEIGHT: cfg_in.dst_height    = dim;
            nnsa_pkg::CSR_FLIP:       cfg_in.flip_vertical = csr_data[0];
            nnsa_pkg::CSR_SPLIT:      cfg_in.split_mode    = csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nnsa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_dest_x (req_dest_x),
      .req_dest_y (req_dest_y),
      .cfg        (cfg_ff),
      .out_valid  (front_valid),
      .out_item   (front_item),
      .out_ready  (queue_ready)
   );

   nnsa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_item   (front_item),
      .in_ready  (queue_ready),
      .out_valid (queue_valid),
      .out_item  (queue_item),
      .out_ready (1'b1)
   );

   nnsa_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (queue_valid),
      .in_item        (queue_item),
      .rsp_valid      (rsp_valid),
      .rsp_source_x   (rsp_source_x),
      .rsp_source_y   (rsp_source_y),
      .rsp_dest_row   (rsp_dest_row),
      .rsp_fill_black (rsp_fill_black),
      .rsp_skip       (rsp_skip)
   );

   a_skip_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_skip |-> !rsp_fill_black && rsp_source_x == '0 &&
      rsp_source_y == '0 && rsp_dest_row == '0)
      else $error("skip response carries data");

   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fill_black |-> rsp_source_x == '0)
      else $error("fill response with nonzero source_x");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("front stalled although back never stalls");
endmodule
